@@ src/ccpg_pkg.sv @@
`default_nettype none
package ccpg_pkg;

  // Pattern select codes
  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeOne  = 2'd1;
  localparam logic [1:0] ModeTwo  = 2'd2;

  localparam int unsigned PosW = 8;

  // Pattern one timing
  localparam logic [PosW:0] P1LastToggle = 9'd116;
  localparam logic [PosW:0] P1Wrap       = 9'd119;

  // Pattern two timing
  localparam logic [PosW:0] P2Window = 9'd121;
  localparam logic [PosW:0] P2Wrap   = 9'd120;

  localparam logic [PosW-1:0] PosMax = 8'd255;

  typedef struct packed {
    logic            crank_level;
    logic            cam_level;
    logic [PosW-1:0] tick_position;
    logic            second_revolution;
  } result_t;

endpackage
`default_nettype wire

@@ src/crank_cam_pattern_generator_core.sv @@
`default_nettype none
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+------------------------------------------
// tick      | in        | in_valid_i/in_stall_o | tick_i
// result    | out       | out_valid_o/out_stall_i | crank_level_o, cam_level_o,
//           |           |                       | tick_position_o, second_revolution_o
// config    | in        | cfg_we_i              | cfg_wdata_i (pattern mode)
//
// One tick transfer per cycle while in_stall_o is low; its result is registered (skid if stalled).
// The state update is a single pass of compare logic from the state registers.
// A two-entry result buffer (output register plus skid register) lets a tick be
// taken while a result is stalled; in_stall_o rises only once both are full.
// Reset clears the tick counter, phase, both lines and the pattern mode.
module crank_cam_pattern_generator_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     tick_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          crank_level_o,
  output logic                          cam_level_o,
  output logic [ccpg_pkg::PosW-1:0]     tick_position_o,
  output logic                          second_revolution_o
);
  import ccpg_pkg::*;

  // Generator state
  logic [1:0]      mode_q;
  logic [PosW-1:0] count_q, count_d;
  logic            phase_q, phase_d;
  logic            crank_q, crank_d;
  logic            cam_q, cam_d;

  // Result buffer
  result_t out_q, skid_q, res_d;
  logic    out_valid_q, skid_valid_q;

  logic          push, pop;
  logic [PosW:0] c;
  logic          run2, gap2;

  assign in_stall_o = skid_valid_q;
  assign push       = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && !out_stall_i;

  // Incremented count, kept one bit wider so that leftover idle counts compare correctly
  assign c = {1'b0, count_q} + 9'd1;

  always_comb begin
    run2 = ((c >= 9'd1) && (c <= 9'd36)) || ((c > 9'd40) && (c <= 9'd76)) ||
           ((c > 9'd80) && (c <= 9'd116));
    gap2 = ((c > 9'd36) && (c <= 9'd40)) || ((c > 9'd76) && (c <= 9'd80)) ||
           ((c > 9'd116) && (c <= 9'd120));
  end

  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    crank_d = crank_q;
    cam_d   = cam_q;
    if (tick_i) begin
      case (mode_q)
        ModeOne: begin
          if (c <= P1LastToggle) begin
            crank_d = !crank_q;
            // Cam edges use the phase from before any wrap on this tick
            if (!phase_q) begin
              if (c inside {9'd1, 9'd16, 9'd26, 9'd56}) cam_d = 1'b0;
              if (c inside {9'd8, 9'd20, 9'd48, 9'd88}) cam_d = 1'b1;
            end else begin
              if (c inside {9'd4, 9'd16, 9'd88}) cam_d = 1'b0;
              if (c inside {9'd8, 9'd48, 9'd96}) cam_d = 1'b1;
            end
          end
          count_d = c[PosW-1:0];
          if (c >= P1LastToggle) begin
            crank_d = 1'b0;
            if (c >= P1Wrap) begin
              count_d = '0;
              phase_d = !phase_q;
            end
          end
        end
        ModeTwo: begin
          if (c <= P2Window) begin
            if (run2) crank_d = !crank_q;
            if (gap2) crank_d = 1'b0;
            if (!phase_q && (c == 9'd3)) cam_d = 1'b1;
            if (!phase_q && (c == 9'd4)) cam_d = 1'b0;
            if (c inside {9'd33, 9'd73, 9'd113}) cam_d = 1'b1;
            if (c inside {9'd34, 9'd74, 9'd114}) cam_d = 1'b0;
          end
          count_d = c[PosW-1:0];
          if (c >= P2Wrap) begin
            count_d = '0;
            phase_d = !phase_q;
          end
        end
        default: begin
          // Idle and the unused code: count only, saturate at the top
          if (count_q != PosMax) count_d = c[PosW-1:0];
        end
      endcase
    end
  end

  always_comb begin
    res_d.crank_level       = crank_d;
    res_d.cam_level         = cam_d;
    res_d.tick_position     = count_d;
    res_d.second_revolution = phase_d;
  end

  // Config register and generator state; advance only on a tick transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      count_q <= '0;
      phase_q <= 1'b0;
      crank_q <= 1'b0;
      cam_q   <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (push) begin
        count_q <= count_d;
        phase_q <= phase_d;
        crank_q <= crank_d;
        cam_q   <= cam_d;
      end
    end
  end

  // Output register with skid: hold a stalled result, park the next one behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push) begin
        if (!out_valid_q || pop) out_valid_q <= 1'b1;
        else skid_valid_q <= 1'b1;
      end else if (pop) begin
        if (skid_valid_q) skid_valid_q <= 1'b0;
        else out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      if (!out_valid_q || pop) out_q <= res_d;
      else skid_q <= res_d;
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign crank_level_o       = out_q.crank_level;
  assign cam_level_o         = out_q.cam_level;
  assign tick_position_o     = out_q.tick_position;
  assign second_revolution_o = out_q.second_revolution;

endmodule
`default_nettype wire
